FILE: rtl/bva_pkg.sv
// ----------------------------------------------------------------------------
// bva_pkg: shared types and constants of the view averaging block
// Holds sizes of the fixed-point datapath, the controller states, the
// command and status groups and the register index codes.
// ----------------------------------------------------------------------------
package bva_pkg;

  // Views accepted per output pixel and fraction bits of the positions.
  localparam int MaxViews = 256;
  localparam int FracBits = 8;

  // Field widths.
  localparam int PosW       = 21;
  localparam int QuadW      = 32;
  localparam int PixW       = 8;
  localparam int DimW       = 13;
  localparam int ViewCountW = 9;
  localparam int NumChan    = 3;

  // Datapath widths derived from the constants above.
  localparam int WgtW  = FracBits + 1;
  localparam int SampW = PixW + FracBits;
  localparam int FullW = PixW + 2 * FracBits;
  localparam int CntW  = $clog2(MaxViews + 1);
  localparam int SumW  = SampW + $clog2(MaxViews);
  localparam int DivW  = SumW + 1 - FracBits;
  localparam int StepW = $clog2(DivW);

  // Configuration port.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic [DimW-1:0] DimReset = DimW'(4096);

  typedef enum logic [0:0] {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StAcc,
    StLoad,
    StDiv,
    StEmit
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [QuadW-1:0]       red_quad;
    logic [QuadW-1:0]       green_quad;
    logic [QuadW-1:0]       blue_quad;
    logic                   last_view;
  } item_t;

  typedef struct packed {
    logic [PixW-1:0]       out_red;
    logic [PixW-1:0]       out_green;
    logic [PixW-1:0]       out_blue;
    logic                  covered;
    logic [ViewCountW-1:0] view_count;
  } result_t;

endpackage

FILE: rtl/bva_in_if.sv
// ----------------------------------------------------------------------------
// bva_in_if: view input channel
// Valid/ready channel that carries one view's sample position and 2x2 pixels.
// ----------------------------------------------------------------------------
interface bva_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [bva_pkg::PosW-1:0] pos_x;
  logic signed [bva_pkg::PosW-1:0] pos_y;
  logic [bva_pkg::QuadW-1:0]      red_quad;
  logic [bva_pkg::QuadW-1:0]      green_quad;
  logic [bva_pkg::QuadW-1:0]      blue_quad;
  logic                           last_view;

  modport source (
    output valid, pos_x, pos_y, red_quad, green_quad, blue_quad, last_view,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, red_quad, green_quad, blue_quad, last_view,
    output ready
  );
endinterface

FILE: rtl/bva_out_if.sv
// ----------------------------------------------------------------------------
// bva_out_if: pixel result channel
// Valid/ready channel that carries one averaged output pixel.
// ----------------------------------------------------------------------------
interface bva_out_if;
  logic                                valid;
  logic                                ready;
  logic [bva_pkg::PixW-1:0]            out_red;
  logic [bva_pkg::PixW-1:0]            out_green;
  logic [bva_pkg::PixW-1:0]            out_blue;
  logic                                covered;
  logic [bva_pkg::ViewCountW-1:0]      view_count;

  modport source (
    output valid, out_red, out_green, out_blue, covered, view_count,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, covered, view_count,
    output ready
  );
endinterface

FILE: rtl/bva_regs.sv
// ----------------------------------------------------------------------------
// bva_regs: configuration registers
// APB-style register file holding the view image width and height.
// ----------------------------------------------------------------------------
module bva_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bva_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bva_pkg::ApbDataW-1:0]  pwdata,
  output logic [bva_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output logic [bva_pkg::DimW-1:0]      width_o,
  output logic [bva_pkg::DimW-1:0]      height_o
);
  import bva_pkg::*;

  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  reg_idx_e        reg_idx;
  logic            wr_en;

  // Registers are word aligned; the low two address bits are ignored.
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write decode.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (reg_idx)
        RegWidth:  width_d  = pwdata[DimW-1:0];
        RegHeight: height_d = pwdata[DimW-1:0];
        default: begin
          width_d  = width_q;
          height_d = height_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimReset;
      height_q <= DimReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      RegWidth:  prdata = ApbDataW'(width_q);
      RegHeight: prdata = ApbDataW'(height_q);
      default:   prdata = '0;
    endcase
  end

  assign width_o  = width_q;
  assign height_o = height_q;

endmodule

FILE: rtl/bva_ctrl.sv
// ----------------------------------------------------------------------------
// bva_ctrl: sequencing controller
// Walks each view through capture, interpolation and accumulation, and on
// the last view runs the divider and hands the pixel to the output register.
// ----------------------------------------------------------------------------
module bva_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bva_pkg::sts_t   sts_i,
  output bva_pkg::cmd_t   cmd_o
);
  import bva_pkg::*;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             step_last;

  assign step_last = (step_q == StepW'(DivW - 1));

  // Next state and divider step counter.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StMul;
      end
      StMul: state_d = StAcc;
      StAcc: begin
        state_d = sts_i.last ? StLoad : StIdle;
      end
      StLoad: begin
        step_d  = '0;
        state_d = StDiv;
      end
      StDiv: begin
        step_d = step_q + StepW'(1);
        if (step_last) state_d = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StMul:  cmd_o.mul  = 1'b1;
      StAcc:  cmd_o.acc  = 1'b1;
      StLoad: cmd_o.load = 1'b1;
      StDiv:  cmd_o.step = 1'b1;
      StEmit: cmd_o.emit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: rtl/bva_dpath.sv
// ----------------------------------------------------------------------------
// bva_dpath: interpolation, accumulation and averaging datapath
// Bilinear weights in two multiply steps, per-channel running sums, three
// restoring dividers that retire one quotient bit a cycle, and the result
// output register.
// ----------------------------------------------------------------------------
module bva_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bva_pkg::item_t           item_i,
  input  logic [bva_pkg::DimW-1:0] width_i,
  input  logic [bva_pkg::DimW-1:0] height_i,
  input  bva_pkg::cmd_t            cmd_i,
  output bva_pkg::sts_t            sts_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bva_pkg::result_t         out_data_o
);
  import bva_pkg::*;

  localparam int LimW = DimW + FracBits;

  // Captured view.
  logic signed [PosW-1:0] pos_x_q, pos_y_q;
  logic [QuadW-1:0]       quad_q [NumChan];
  logic                   last_q;

  // First multiply step results.
  logic [SampW-1:0] top_q [NumChan];
  logic [SampW-1:0] bot_q [NumChan];
  logic [WgtW-1:0]  wy0_q, wy1_q;
  logic             take_q;

  // Pixel state.
  logic [SumW-1:0] sum_q [NumChan];
  logic [CntW-1:0] inside_q;
  logic [CntW-1:0] seen_q;

  // Dividers.
  logic [DivW-1:0] quo_q [NumChan];
  logic [CntW-1:0] rem_q [NumChan];

  // Output register.
  logic    out_valid_q;
  result_t out_q;

  // Bounds test: 0 <= pos < (size - 1) in fixed point, size of at least two.
  logic [LimW-1:0] lim_x, lim_y;
  logic            in_x, in_y, view_in;

  assign lim_x   = {width_i - DimW'(1), FracBits'(0)};
  assign lim_y   = {height_i - DimW'(1), FracBits'(0)};
  assign in_x    = !pos_x_q[PosW-1] && (width_i >= DimW'(2))
                   && (LimW'(pos_x_q[PosW-2:0]) < lim_x);
  assign in_y    = !pos_y_q[PosW-1] && (height_i >= DimW'(2))
                   && (LimW'(pos_y_q[PosW-2:0]) < lim_y);
  assign view_in = in_x && in_y;

  // Horizontal weights.
  logic [WgtW-1:0] wx0, wx1;
  assign wx1 = {1'b0, pos_x_q[FracBits-1:0]};
  assign wx0 = WgtW'(1 << FracBits) - wx1;

  // First multiply step: blend along x for the top and bottom rows.
  logic [SampW:0] top_w [NumChan];
  logic [SampW:0] bot_w [NumChan];
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      top_w[c] = (SampW+1)'(quad_q[c][7:0]) * (SampW+1)'(wx0)
               + (SampW+1)'(quad_q[c][15:8]) * (SampW+1)'(wx1);
      bot_w[c] = (SampW+1)'(quad_q[c][23:16]) * (SampW+1)'(wx0)
               + (SampW+1)'(quad_q[c][31:24]) * (SampW+1)'(wx1);
    end
  end

  // Second multiply step: blend along y and round to FracBits fraction bits.
  logic [FullW:0]   full_w [NumChan];
  logic [SampW-1:0] samp_w [NumChan];
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      full_w[c] = (FullW+1)'(top_q[c]) * (FullW+1)'(wy0_q)
                + (FullW+1)'(bot_q[c]) * (FullW+1)'(wy1_q)
                + (FullW+1)'(1 << (FracBits - 1));
      samp_w[c] = full_w[c][FracBits +: SampW];
    end
  end

  // Divider operands: floor((sum + count*S/2) / S) divided by the count.
  logic [SumW:0]   rnd_w [NumChan];
  logic [CntW:0]   trial_w [NumChan];
  logic            fits_w [NumChan];
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      rnd_w[c]   = (SumW+1)'(sum_q[c]) + ((SumW+1)'(inside_q) << (FracBits - 1));
      trial_w[c] = {rem_q[c], quo_q[c][DivW-1]};
      fits_w[c]  = (trial_w[c] >= {1'b0, inside_q});
    end
  end

  // Clamped averages.
  logic [PixW-1:0] avg_w [NumChan];
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      avg_w[c] = (quo_q[c][DivW-1:PixW] != '0) ? '1 : quo_q[c][PixW-1:0];
    end
  end

  // Payload registers: capture, multiply stage, divider and output data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pos_x_q   <= item_i.pos_x;
      pos_y_q   <= item_i.pos_y;
      quad_q[0] <= item_i.red_quad;
      quad_q[1] <= item_i.green_quad;
      quad_q[2] <= item_i.blue_quad;
    end
    if (cmd_i.mul) begin
      wy1_q <= {1'b0, pos_y_q[FracBits-1:0]};
      wy0_q <= WgtW'(1 << FracBits) - {1'b0, pos_y_q[FracBits-1:0]};
      for (int c = 0; c < NumChan; c++) begin
        top_q[c] <= top_w[c][SampW-1:0];
        bot_q[c] <= bot_w[c][SampW-1:0];
      end
    end
    for (int c = 0; c < NumChan; c++) begin
      if (cmd_i.load) begin
        quo_q[c] <= rnd_w[c][SumW:FracBits];
        rem_q[c] <= '0;
      end else if (cmd_i.step) begin
        quo_q[c] <= {quo_q[c][DivW-2:0], fits_w[c]};
        rem_q[c] <= fits_w[c] ? CntW'(trial_w[c] - {1'b0, inside_q})
                              : trial_w[c][CntW-1:0];
      end
    end
    if (cmd_i.emit) begin
      if (inside_q == '0) begin
        out_q <= '0;
      end else begin
        out_q.out_red    <= avg_w[0];
        out_q.out_green  <= avg_w[1];
        out_q.out_blue   <= avg_w[2];
        out_q.covered    <= 1'b1;
        out_q.view_count <= ViewCountW'(inside_q);
      end
    end
  end

  // Control state: last mark, accumulate gate, sums, counts, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      take_q      <= 1'b0;
      inside_q    <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NumChan; c++) sum_q[c] <= '0;
    end else begin
      if (cmd_i.capture) last_q <= item_i.last_view;
      if (cmd_i.mul) begin
        take_q <= view_in && (seen_q < CntW'(MaxViews));
        if (seen_q < CntW'(MaxViews)) seen_q <= seen_q + CntW'(1);
      end
      if (cmd_i.acc && take_q) begin
        inside_q <= inside_q + CntW'(1);
        for (int c = 0; c < NumChan; c++) sum_q[c] <= sum_q[c] + SumW'(samp_w[c]);
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        inside_q    <= '0;
        seen_q      <= '0;
        for (int c = 0; c < NumChan; c++) sum_q[c] <= '0;
      end
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

FILE: rtl/bilinear_view_average.sv
// ----------------------------------------------------------------------------
// bilinear_view_average: refocused pixel from a stream of view samples
// Interpolates each in-bounds view bilinearly, sums per channel and emits
// the rounded, clamped average on the view marked last.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transfer carries
//   in_ch     sink       pos_x, pos_y, red/green/blue_quad, last_view
//   out_ch    source     out_red, out_green, out_blue, covered, view_count
//   APB       slave      image_width at 0x0, image_height at 0x4
//
// A view passes through capture, x blend, then y blend and accumulate.
// A last view adds a load step, the bit-serial division of all DivW (17)
// quotient bits and the move of the result into the output register.
// The output register frees the input side; a second pixel waits at the
// end of its division only while the previous result is not yet taken.
// Reset clears the sums, the counts and the output valid at once.
//
module bilinear_view_average (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bva_in_if.sink                        in_ch,
  bva_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bva_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bva_pkg::ApbDataW-1:0]  pwdata,
  output logic [bva_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import bva_pkg::*;

  logic [DimW-1:0] width, height;
  item_t           in_item;
  result_t         out_item;
  cmd_t            cmd;
  sts_t            sts;
  logic            out_valid;

  // Configuration registers.
  bva_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .width_o  (width),
    .height_o (height)
  );

  // Gather the input payload.
  assign in_item.pos_x      = in_ch.pos_x;
  assign in_item.pos_y      = in_ch.pos_y;
  assign in_item.red_quad   = in_ch.red_quad;
  assign in_item.green_quad = in_ch.green_quad;
  assign in_item.blue_quad  = in_ch.blue_quad;
  assign in_item.last_view  = in_ch.last_view;

  // Sequencing.
  bva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and output register.
  bva_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_item),
    .width_i     (width),
    .height_i    (height),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .out_data_o  (out_item)
  );

  // Drive the result channel.
  assign out_ch.valid      = out_valid;
  assign out_ch.out_red    = out_item.out_red;
  assign out_ch.out_green  = out_item.out_green;
  assign out_ch.out_blue   = out_item.out_blue;
  assign out_ch.covered    = out_item.covered;
  assign out_ch.view_count = out_item.view_count;

endmodule

FILE: rtl/bva_checker.sv
// ----------------------------------------------------------------------------
// bva_checker: port-level checks of the view averaging block
// Watches the channels of the top level and flags results that cannot occur.
// ----------------------------------------------------------------------------
module bva_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [bva_pkg::PixW-1:0]         out_red_i,
  input logic [bva_pkg::PixW-1:0]         out_green_i,
  input logic [bva_pkg::PixW-1:0]         out_blue_i,
  input logic                             covered_i,
  input logic [bva_pkg::ViewCountW-1:0]   view_count_i
);
  import bva_pkg::*;

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // An uncovered pixel reports zeros throughout.
  a_uncovered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !covered_i |->
      (out_red_i == '0) && (out_green_i == '0) && (out_blue_i == '0)
      && (view_count_i == '0))
    else $error("uncovered pixel with nonzero fields");

  // A covered pixel counts between one and the view limit.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && covered_i |->
      (view_count_i != '0) && (view_count_i <= ViewCountW'(MaxViews)))
    else $error("view count out of range");

  // Each view is worked through before the next one is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on consecutive cycles");

endmodule

bind bilinear_view_average bva_checker u_bva_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_red_i    (out_ch.out_red),
  .out_green_i  (out_ch.out_green),
  .out_blue_i   (out_ch.out_blue),
  .covered_i    (out_ch.covered),
  .view_count_i (out_ch.view_count)
);
